// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module lss_checker.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/lss_pkg.sv =====
// Shared types and constants for the light signal sequencer.
// No dependencies.
`default_nettype none

package lss_pkg;

  localparam int TIMER_W = 16;
  localparam int CNT_W   = 8;
  localparam int OUT_W   = 6;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Message codes
  localparam logic [2:0] MSG_NONE = 3'd0;
  localparam logic [2:0] MSG_ACK  = 3'd1;
  localparam logic [2:0] MSG_NACK = 3'd2;
  localparam logic [2:0] MSG_ATTN = 3'd3;
  localparam logic [2:0] MSG_DONE = 3'd4;

  // Register indexes (byte address 4*i)
  localparam logic [1:0] REG_ON_TIME     = 2'd0;
  localparam logic [1:0] REG_OFF_TIME    = 2'd1;
  localparam logic [1:0] REG_FLASH_COUNT = 2'd2;

  localparam logic [TIMER_W-1:0] ON_TIME_RST     = 16'd200;
  localparam logic [TIMER_W-1:0] OFF_TIME_RST    = 16'd200;
  localparam logic [CNT_W-1:0]   FLASH_COUNT_RST = 8'd10;

  typedef struct packed {
    logic [2:0] msg;
    logic [9:0] elapsed_ms;
    logic       manual_enable;
    logic       light_up;
    logic       light_down;
    logic       light_reset;
  } lss_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] light_level;
    logic             pattern_active;
  } lss_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/light_signal_sequencer_unit.sv =====
// Light signal sequencer: manual level control plus ack/nack/attention/ramp patterns.
// Depends on lss_pkg.
`default_nettype none

// Usage
//  - Input channel (in_valid/in_ready/in_data): one beat is one control pass,
//    carrying the message code, elapsed milliseconds and the manual buttons.
//  - Result channel (out_valid/out_ready/out_data): one beat per input beat,
//    the light level after that pass and whether any pattern is running.
//  - APB port: on_time at 0x0, off_time at 0x4, flash_count at 0x8. Write only
//    while no pass is outstanding. pready is tied high; reads return the value.
//  - Registered: the result appears in the cycle after the input beat is taken.
//  - Throughput: one pass per cycle unless stalled. Each pass is a short chain of
//    compare/add logic from the state registers into the result register.
//  - Stall: the result register holds while out_ready is low; in_ready then
//    drops, and rises again in the same cycle the held result is taken.
//  - Reset (rst_n low, synchronous): level, timer, counter and all pattern
//    machines go idle/zero, registers return to 200/200/10, out_valid clears.
//  - LIGHT_MAX sets the top level; light_level carries its low six bits.
module light_signal_sequencer_unit
  import lss_pkg::*;
#(
  parameter int unsigned LIGHT_MAX = 63
) (
  input  wire               clk,
  input  wire               rst_n,
  // input channel
  input  wire               in_valid,
  output logic              in_ready,
  input  lss_in_t           in_data,
  // result channel
  output logic              out_valid,
  input  wire               out_ready,
  output lss_out_t          out_data,
  // configuration
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [ADDR_W-1:0] paddr,
  input  wire  [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int LVL_W = (LIGHT_MAX < 2) ? 1 : $clog2(LIGHT_MAX + 1);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LIGHT_MAX);

  typedef enum logic [1:0] {ATT_REST, ATT_ON, ATT_OFF} att_t;
  typedef enum logic [1:0] {NACK_IDLE, NACK_ON0, NACK_OFF0, NACK_ON1} nack_t;
  typedef enum logic [1:0] {RAMP_IDLE, RAMP_UP, RAMP_DOWN} ramp_t;

  // config registers
  logic [TIMER_W-1:0] on_time_r, off_time_r;
  logic [CNT_W-1:0]   flash_count_r;

  // pass state
  logic [LVL_W-1:0]   lvl_r,   lvl_nxt;
  logic [TIMER_W-1:0] tmr_r,   tmr_nxt;
  logic [CNT_W-1:0]   fcnt_r,  fcnt_nxt;
  att_t               att_r,   att_nxt;
  nack_t              nack_r,  nack_nxt;
  logic               ack_r,   ack_nxt;
  ramp_t              ramp_r,  ramp_nxt;

  // result register
  logic               out_valid_r;
  lss_out_t           out_data_r, out_data_nxt;

  logic               in_acc;
  logic               cfg_wr;
  logic [TIMER_W:0]   tmr_sum;
  logic [LVL_W+OUT_W-1:0] lvl_wide;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    unique case (paddr[3:2])
      REG_ON_TIME:     prdata = DATA_W'(on_time_r);
      REG_OFF_TIME:    prdata = DATA_W'(off_time_r);
      REG_FLASH_COUNT: prdata = DATA_W'(flash_count_r);
      default:         prdata = '0;
    endcase
  end

  // One control pass, in the fixed order: timer, manual, message, attention,
  // nack, ack, ramp. Later stages override the level set by earlier ones.
  always_comb begin
    lvl_nxt  = lvl_r;
    fcnt_nxt = fcnt_r;
    att_nxt  = att_r;
    nack_nxt = nack_r;
    ack_nxt  = ack_r;
    ramp_nxt = ramp_r;

    // saturating timer
    tmr_sum = {1'b0, tmr_r} + (TIMER_W + 1)'(in_data.elapsed_ms);
    tmr_nxt = tmr_sum[TIMER_W] ? TIMER_MAX : tmr_sum[TIMER_W-1:0];

    // manual buttons
    if (in_data.manual_enable) begin
      if (in_data.light_up) begin
        if (lvl_nxt < LVL_MAX) lvl_nxt = lvl_nxt + 1'b1;
      end else if (in_data.light_down) begin
        if (lvl_nxt != '0) lvl_nxt = lvl_nxt - 1'b1;
      end
      if (lvl_nxt > LVL_MAX) lvl_nxt = LVL_MAX;
      if (in_data.light_reset) lvl_nxt = '0;
    end

    // message kicks off a pattern; unknown codes only clear level and timer
    if (in_data.msg != MSG_NONE) begin
      case (in_data.msg)
        MSG_ACK:  ack_nxt  = 1'b1;
        MSG_NACK: nack_nxt = NACK_ON0;
        MSG_ATTN: begin
          att_nxt  = ATT_ON;
          fcnt_nxt = '0;
        end
        MSG_DONE: ramp_nxt = RAMP_UP;
        default: ;
      endcase
      lvl_nxt = '0;
      tmr_nxt = '0;
    end

    // attention
    if (att_nxt == ATT_ON) begin
      lvl_nxt = LVL_MAX;
      if (tmr_nxt > on_time_r) begin
        att_nxt = ATT_OFF;
        tmr_nxt = '0;
      end
    end else if (att_nxt == ATT_OFF) begin
      lvl_nxt = '0;
      if (tmr_nxt > off_time_r) begin
        att_nxt  = ATT_ON;
        tmr_nxt  = '0;
        fcnt_nxt = fcnt_nxt + 1'b1;
        if (fcnt_nxt >= flash_count_r) begin
          att_nxt  = ATT_REST;
          fcnt_nxt = '0;
        end
      end
    end

    // nack: on, off, on
    if (nack_nxt == NACK_ON0) begin
      lvl_nxt = LVL_MAX;
      if (tmr_nxt > on_time_r) begin
        nack_nxt = NACK_OFF0;
        tmr_nxt  = '0;
      end
    end else if (nack_nxt == NACK_OFF0) begin
      lvl_nxt = '0;
      if (tmr_nxt > off_time_r) begin
        nack_nxt = NACK_ON1;
        tmr_nxt  = '0;
      end
    end else if (nack_nxt == NACK_ON1) begin
      lvl_nxt = LVL_MAX;
      if (tmr_nxt > on_time_r) begin
        nack_nxt = NACK_IDLE;
        tmr_nxt  = '0;
        lvl_nxt  = '0;
      end
    end

    // ack: one flash
    if (ack_nxt) begin
      lvl_nxt = LVL_MAX;
      if (tmr_nxt > on_time_r) begin
        ack_nxt = 1'b0;
        tmr_nxt = '0;
        lvl_nxt = '0;
      end
    end

    // task-complete ramp
    if (ramp_nxt == RAMP_UP) begin
      if (lvl_nxt < LVL_MAX) lvl_nxt = lvl_nxt + 1'b1;
      if (lvl_nxt >= LVL_MAX) begin
        lvl_nxt  = LVL_MAX;
        ramp_nxt = RAMP_DOWN;
      end
    end else if (ramp_nxt == RAMP_DOWN) begin
      if (lvl_nxt > LVL_MAX) lvl_nxt = LVL_MAX;
      if (lvl_nxt != '0) lvl_nxt = lvl_nxt - 1'b1;
      if (lvl_nxt == '0) ramp_nxt = RAMP_IDLE;
    end

    lvl_wide = {{OUT_W{1'b0}}, lvl_nxt};
    out_data_nxt.light_level    = lvl_wide[OUT_W-1:0];
    out_data_nxt.pattern_active = (att_nxt != ATT_REST) || (nack_nxt != NACK_IDLE) ||
                                  ack_nxt || (ramp_nxt != RAMP_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_time_r     <= ON_TIME_RST;
      off_time_r    <= OFF_TIME_RST;
      flash_count_r <= FLASH_COUNT_RST;
      lvl_r         <= '0;
      tmr_r         <= '0;
      fcnt_r        <= '0;
      att_r         <= ATT_REST;
      nack_r        <= NACK_IDLE;
      ack_r         <= 1'b0;
      ramp_r        <= RAMP_IDLE;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_ON_TIME:     on_time_r     <= pwdata[TIMER_W-1:0];
          REG_OFF_TIME:    off_time_r    <= pwdata[TIMER_W-1:0];
          REG_FLASH_COUNT: flash_count_r <= pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        lvl_r       <= lvl_nxt;
        tmr_r       <= tmr_nxt;
        fcnt_r      <= fcnt_nxt;
        att_r       <= att_nxt;
        nack_r      <= nack_nxt;
        ack_r       <= ack_nxt;
        ramp_r      <= ramp_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lss_checker.sv =====
// Port-level checks for light_signal_sequencer_unit, attached by bind.
// Depends on lss_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lss_checker
  import lss_pkg::*;
(
  input wire      clk,
  input wire      rst_n,
  input wire      in_valid,
  input wire      in_ready,
  input lss_in_t  in_data,
  input wire      out_valid,
  input wire      out_ready,
  input lss_out_t out_data
);

  logic in_acc;
  logic msg_known;

  assign in_acc    = in_valid && in_ready;
  assign msg_known = (in_data.msg == MSG_ACK) || (in_data.msg == MSG_NACK) ||
                     (in_data.msg == MSG_ATTN) || (in_data.msg == MSG_DONE);

  // a taken pass shows its result on the next cycle
  `LSS_ASSERT_NEXT(a_result_follows, clk, rst_n, in_acc, out_valid)
  // input only stalls behind a held result
  `LSS_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready)
  // a started pattern cannot end on its first pass
  `LSS_ASSERT_NEXT(a_pattern_starts, clk, rst_n, in_acc && msg_known, out_data.pattern_active)
  // held result stays put
  `LSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_data))

endmodule

bind light_signal_sequencer_unit lss_checker u_lss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
